// File: rtl/core/tsb_pkg.sv
`timescale 1ns / 1ps

package tsb_pkg;

  // Run limits and field widths.
  localparam int MAX_READINGS = 128;
  localparam int TEMP_W       = 15;
  localparam int READING_W    = 16;
  localparam int CNT_W        = 8;
  localparam int POS_W        = 8;
  localparam int IDX_W        = 7;
  localparam int SUM_W        = 23;
  localparam int MEAN_W       = 15;
  localparam int REM_W        = SUM_W - MEAN_W;
  localparam int UNIT_W       = SUM_W + 1;
  localparam int DCNT_W       = 4;
  localparam int NUM_BINS     = 4;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register reset values, hundredths of a degree.
  localparam logic [TEMP_W-1:0] NORMAL_RESET   = 15'd2900;
  localparam logic [TEMP_W-1:0] WARNING_RESET  = 15'd4400;
  localparam logic [TEMP_W-1:0] CRITICAL_RESET = 15'd5900;
  localparam logic [TEMP_W-1:0] ALARM_RESET    = 15'd4500;

  // Register indexes.
  localparam logic [1:0] REG_NORMAL   = 2'd0;
  localparam logic [1:0] REG_WARNING  = 2'd1;
  localparam logic [1:0] REG_CRITICAL = 2'd2;
  localparam logic [1:0] REG_ALARM    = 2'd3;

  // Histogram bins.
  localparam int BIN_NORMAL   = 0;
  localparam int BIN_WARNING  = 1;
  localparam int BIN_CRITICAL = 2;
  localparam int BIN_SHUTDOWN = 3;

  typedef struct packed {
    logic [TEMP_W-1:0] normal_limit;
    logic [TEMP_W-1:0] warning_limit;
    logic [TEMP_W-1:0] critical_limit;
    logic [TEMP_W-1:0] alarm_threshold;
  } cfg_t;

  // Request to the shared add/subtract unit.
  typedef struct packed {
    logic [UNIT_W-1:0] a;
    logic [UNIT_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [UNIT_W-1:0] res;
    logic              neg;
  } alu_res_t;

  typedef struct packed {
    logic              valid;
    logic [TEMP_W-1:0] min_reading;
    logic [TEMP_W-1:0] max_reading;
    logic [MEAN_W-1:0] mean_reading;
    logic [CNT_W-1:0]  normal_count;
    logic [CNT_W-1:0]  warning_count;
    logic [CNT_W-1:0]  critical_count;
    logic [CNT_W-1:0]  shutdown_count;
    logic [CNT_W-1:0]  error_count;
    logic              alarm_found;
    logic [IDX_W-1:0]  alarm_index;
    logic              none_valid;
  } result_t;

  // Counter that stops at the run limit.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v < CNT_W'(MAX_READINGS)) ? v + CNT_W'(1) : v;
  endfunction

endpackage

// File: rtl/core/tsb_alu.sv
`timescale 1ns / 1ps

module tsb_alu import tsb_pkg::*; (
  input  alu_req_t req,
  output alu_res_t rsp
);

  logic [UNIT_W-1:0] b_eff;

  // One adder serves add, subtract and compare; the top bit flags a negative difference.
  assign b_eff   = req.sub ? ~req.b : req.b;
  assign rsp.res = req.a + b_eff + UNIT_W'(req.sub);
  assign rsp.neg = rsp.res[UNIT_W-1];

endmodule

// File: rtl/core/tsb_regs.sv
`timescale 1ns / 1ps

module tsb_regs import tsb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign cfg     = cfg_r;

  // Register write on the access phase of a transfer.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_NORMAL:   cfg_nxt.normal_limit    = pwdata[TEMP_W-1:0];
        REG_WARNING:  cfg_nxt.warning_limit   = pwdata[TEMP_W-1:0];
        REG_CRITICAL: cfg_nxt.critical_limit  = pwdata[TEMP_W-1:0];
        REG_ALARM:    cfg_nxt.alarm_threshold = pwdata[TEMP_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_limit    <= NORMAL_RESET;
      cfg_r.warning_limit   <= WARNING_RESET;
      cfg_r.critical_limit  <= CRITICAL_RESET;
      cfg_r.alarm_threshold <= ALARM_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read data is the selected register, zero extended.
  always_comb begin
    unique case (reg_idx)
      REG_NORMAL:   prdata = DATA_W'(cfg_r.normal_limit);
      REG_WARNING:  prdata = DATA_W'(cfg_r.warning_limit);
      REG_CRITICAL: prdata = DATA_W'(cfg_r.critical_limit);
      REG_ALARM:    prdata = DATA_W'(cfg_r.alarm_threshold);
    endcase
  end

endmodule

// File: rtl/core/tsb_seq.sv
`timescale 1ns / 1ps

module tsb_seq import tsb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [READING_W-1:0] reading,
  input  logic                 last,
  input  cfg_t                 cfg,
  output logic                 busy,
  output alu_req_t             alu_req,
  input  alu_res_t             alu_rsp,
  output result_t              result
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_MIN   = 11'b000_0000_0010,
    ST_MAX   = 11'b000_0000_0100,
    ST_NORM  = 11'b000_0000_1000,
    ST_WARN  = 11'b000_0001_0000,
    ST_CRIT  = 11'b000_0010_0000,
    ST_ALARM = 11'b000_0100_0000,
    ST_SUM   = 11'b000_1000_0000,
    ST_END   = 11'b001_0000_0000,
    ST_DIV   = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [TEMP_W-1:0] rd_r, rd_nxt;
  logic              neg_r, neg_nxt;
  logic              last_r, last_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  vcnt_r, vcnt_nxt;
  logic [TEMP_W-1:0] min_r, min_nxt;
  logic [TEMP_W-1:0] max_r, max_nxt;
  logic              seen_r, seen_nxt;
  logic [CNT_W-1:0]  bin_r [NUM_BINS];
  logic [CNT_W-1:0]  bin_nxt [NUM_BINS];
  logic [CNT_W-1:0]  err_r, err_nxt;
  logic              alarm_r, alarm_nxt;
  logic [IDX_W-1:0]  apos_r, apos_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [REM_W:0]    trial;
  logic              qbit;

  assign busy  = (state_r != ST_IDLE);
  assign trial = {rem_r, sum_r[MEAN_W-1]};
  assign qbit  = ~alu_rsp.neg;

  // Operand selection for the shared unit.
  always_comb begin
    alu_req = '0;
    unique case (state_r)
      ST_MIN: begin
        alu_req.a   = UNIT_W'(rd_r);
        alu_req.b   = UNIT_W'(min_r);
        alu_req.sub = 1'b1;
      end
      ST_MAX: begin
        alu_req.a   = UNIT_W'(max_r);
        alu_req.b   = UNIT_W'(rd_r);
        alu_req.sub = 1'b1;
      end
      ST_NORM: begin
        alu_req.a   = UNIT_W'(cfg.normal_limit);
        alu_req.b   = UNIT_W'(rd_r);
        alu_req.sub = 1'b1;
      end
      ST_WARN: begin
        alu_req.a   = UNIT_W'(cfg.warning_limit);
        alu_req.b   = UNIT_W'(rd_r);
        alu_req.sub = 1'b1;
      end
      ST_CRIT: begin
        alu_req.a   = UNIT_W'(cfg.critical_limit);
        alu_req.b   = UNIT_W'(rd_r);
        alu_req.sub = 1'b1;
      end
      ST_ALARM: begin
        alu_req.a   = UNIT_W'(rd_r);
        alu_req.b   = UNIT_W'(cfg.alarm_threshold);
        alu_req.sub = 1'b1;
      end
      ST_SUM: begin
        alu_req.a   = UNIT_W'(sum_r);
        alu_req.b   = UNIT_W'(rd_r);
        alu_req.sub = 1'b0;
      end
      ST_DIV: begin
        alu_req.a   = UNIT_W'(trial);
        alu_req.b   = UNIT_W'(vcnt_r);
        alu_req.sub = 1'b1;
      end
      ST_IDLE, ST_END, ST_OUT: begin
        alu_req = '0;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // Sequencer: one compare or add per step, then restoring division on the last reading.
  always_comb begin
    state_nxt = state_r;
    rd_nxt    = rd_r;
    neg_nxt   = neg_r;
    last_nxt  = last_r;
    sum_nxt   = sum_r;
    vcnt_nxt  = vcnt_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    seen_nxt  = seen_r;
    bin_nxt   = bin_r;
    err_nxt   = err_r;
    alarm_nxt = alarm_r;
    apos_nxt  = apos_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    dcnt_nxt  = dcnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          rd_nxt    = reading[TEMP_W-1:0];
          neg_nxt   = reading[READING_W-1];
          last_nxt  = last;
          state_nxt = reading[READING_W-1] ? ST_END : ST_MIN;
        end
      end
      ST_MIN: begin
        if (!seen_r || alu_rsp.neg) begin
          min_nxt = rd_r;
        end
        state_nxt = ST_MAX;
      end
      ST_MAX: begin
        if (!seen_r || alu_rsp.neg) begin
          max_nxt = rd_r;
        end
        seen_nxt  = 1'b1;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (!alu_rsp.neg) begin
          bin_nxt[BIN_NORMAL] = sat_inc(bin_r[BIN_NORMAL]);
          state_nxt           = ST_ALARM;
        end else begin
          state_nxt = ST_WARN;
        end
      end
      ST_WARN: begin
        if (!alu_rsp.neg) begin
          bin_nxt[BIN_WARNING] = sat_inc(bin_r[BIN_WARNING]);
          state_nxt            = ST_ALARM;
        end else begin
          state_nxt = ST_CRIT;
        end
      end
      ST_CRIT: begin
        if (!alu_rsp.neg) begin
          bin_nxt[BIN_CRITICAL] = sat_inc(bin_r[BIN_CRITICAL]);
        end else begin
          bin_nxt[BIN_SHUTDOWN] = sat_inc(bin_r[BIN_SHUTDOWN]);
        end
        state_nxt = ST_ALARM;
      end
      ST_ALARM: begin
        if (!alarm_r && !alu_rsp.neg) begin
          alarm_nxt = 1'b1;
          apos_nxt  = pos_r[IDX_W-1:0];
        end
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        // The mean covers only the readings that fit under the run limit.
        if (vcnt_r < CNT_W'(MAX_READINGS)) begin
          sum_nxt  = alu_rsp.res[SUM_W-1:0];
          vcnt_nxt = vcnt_r + CNT_W'(1);
        end
        state_nxt = ST_END;
      end
      ST_END: begin
        if (neg_r) begin
          err_nxt = sat_inc(err_r);
        end
        if (!last_r) begin
          if (pos_r < POS_W'(MAX_READINGS - 1)) begin
            pos_nxt = pos_r + POS_W'(1);
          end
          state_nxt = ST_IDLE;
        end else if (seen_r || !neg_r) begin
          // Quotient fits in MEAN_W bits, so the upper sum bits seed the remainder.
          rem_nxt   = sum_r[SUM_W-1:MEAN_W];
          dcnt_nxt  = DCNT_W'(MEAN_W - 1);
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        rem_nxt              = qbit ? alu_rsp.res[REM_W-1:0] : trial[REM_W-1:0];
        sum_nxt[MEAN_W-1:0]  = {sum_r[MEAN_W-2:0], qbit};
        dcnt_nxt             = dcnt_r - DCNT_W'(1);
        if (dcnt_r == '0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        sum_nxt   = '0;
        vcnt_nxt  = '0;
        min_nxt   = '0;
        max_nxt   = '0;
        seen_nxt  = 1'b0;
        bin_nxt   = '{default: '0};
        err_nxt   = '0;
        alarm_nxt = 1'b0;
        apos_nxt  = '0;
        pos_nxt   = '0;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and run state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sum_r   <= '0;
      vcnt_r  <= '0;
      min_r   <= '0;
      max_r   <= '0;
      seen_r  <= 1'b0;
      bin_r   <= '{default: '0};
      err_r   <= '0;
      alarm_r <= 1'b0;
      apos_r  <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      vcnt_r  <= vcnt_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      seen_r  <= seen_nxt;
      bin_r   <= bin_nxt;
      err_r   <= err_nxt;
      alarm_r <= alarm_nxt;
      apos_r  <= apos_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Item and division payload.
  always_ff @(posedge clk) begin
    rd_r   <= rd_nxt;
    neg_r  <= neg_nxt;
    last_r <= last_nxt;
    rem_r  <= rem_nxt;
    dcnt_r <= dcnt_nxt;
  end

  // Summary fields; unused fields are already zero when no reading was valid.
  assign result.valid          = (state_r == ST_OUT);
  assign result.min_reading    = min_r;
  assign result.max_reading    = max_r;
  assign result.mean_reading   = sum_r[MEAN_W-1:0];
  assign result.normal_count   = bin_r[BIN_NORMAL];
  assign result.warning_count  = bin_r[BIN_WARNING];
  assign result.critical_count = bin_r[BIN_CRITICAL];
  assign result.shutdown_count = bin_r[BIN_SHUTDOWN];
  assign result.error_count    = err_r;
  assign result.alarm_found    = alarm_r;
  assign result.alarm_index    = apos_r;
  assign result.none_valid     = ~seen_r;

endmodule

// File: rtl/core/temperature_stats_binner.sv
`timescale 1ns / 1ps
// Temperature run statistics with a four-band histogram.
// Input: a reading (signed hundredths of a degree) and a last flag are taken
// at a clock edge with start high and busy low. Negative readings are counted
// as errors and otherwise skipped.
// Each reading passes through one shared add/subtract unit, one operation per
// cycle: a valid reading keeps busy high through min, max, one to three band
// compares, alarm, sum and wrap-up; an error reading through the wrap-up only.
// A reading marked last adds restoring division (one quotient bit per cycle,
// skipped when no reading was valid) and an output step.
// Output: out_valid is high for exactly one cycle with the summary on the
// out_ ports; the receiver cannot stall, so the result must be taken then.
// The run state clears after the summary.
// Configuration: APB-style port, four 15-bit limit registers at byte addresses
// 0, 4, 8 and 12. The user writes them only while the block is idle; the block
// does not enforce this. Reset (rst_n low, synchronous) restores the register
// defaults and clears the run state.

module temperature_stats_binner import tsb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [READING_W-1:0] in_reading,
  input  logic                 in_last,
  output logic                 out_valid,
  output logic [TEMP_W-1:0]    out_min_reading,
  output logic [TEMP_W-1:0]    out_max_reading,
  output logic [MEAN_W-1:0]    out_mean_reading,
  output logic [CNT_W-1:0]     out_normal_count,
  output logic [CNT_W-1:0]     out_warning_count,
  output logic [CNT_W-1:0]     out_critical_count,
  output logic [CNT_W-1:0]     out_shutdown_count,
  output logic [CNT_W-1:0]     out_error_count,
  output logic                 out_alarm_found,
  output logic [IDX_W-1:0]     out_alarm_index,
  output logic                 out_none_valid,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  cfg_t     cfg;
  alu_req_t alu_req;
  alu_res_t alu_rsp;
  result_t  result;

  // Configuration registers.
  tsb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer and run state.
  tsb_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .reading (in_reading),
    .last    (in_last),
    .cfg     (cfg),
    .busy    (busy),
    .alu_req (alu_req),
    .alu_rsp (alu_rsp),
    .result  (result)
  );

  // Shared add/subtract unit.
  tsb_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign out_valid          = result.valid;
  assign out_min_reading    = result.min_reading;
  assign out_max_reading    = result.max_reading;
  assign out_mean_reading   = result.mean_reading;
  assign out_normal_count   = result.normal_count;
  assign out_warning_count  = result.warning_count;
  assign out_critical_count = result.critical_count;
  assign out_shutdown_count = result.shutdown_count;
  assign out_error_count    = result.error_count;
  assign out_alarm_found    = result.alarm_found;
  assign out_alarm_index    = result.alarm_index;
  assign out_none_valid     = result.none_valid;

`ifndef SYNTH
  // An accepted reading always makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted reading");

  // A summary transfer only happens while busy, and the block is free right after.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("summary shown while idle");

  a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!busy && !out_valid))
    else $error("block still busy after the summary transfer");

  // An empty run reports zero statistics.
  a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_none_valid) |-> (out_min_reading == '0 && out_max_reading == '0
      && out_mean_reading == '0 && !out_alarm_found))
    else $error("empty run reported nonzero statistics");
`endif

endmodule
